[rtl/ppmd_pkg.sv]
// shared types and constants of the ppm stream decoder
package ppmd_pkg;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_OVER_MAX  = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED = 3'd3;
  localparam logic [2:0] ERR_HEADER    = 3'd4;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [16:0] MAXVAL_CLAMP = 17'h10000;
  localparam logic [16:0] NARROW_MAX   = 17'd255;
  localparam int          QUO_BITS     = 16;

  typedef struct packed {
    logic take;
    logic div_step;
    logic div_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_div;
    logic div_done;
  } dp_sts_t;

endpackage

[rtl/ppmd_stream_if.sv]
// byte input and result output channel interfaces
interface ppmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;
  logic       stream_end;
  modport source (output valid, in_byte, start_of_file, stream_end, input ready);
  modport sink (input valid, in_byte, start_of_file, stream_end, output ready);
endinterface

interface ppmd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [16:0] max_value;
  logic        wide_samples;
  logic [15:0] sample;
  logic [1:0]  channel;
  logic [15:0] column;
  logic [15:0] row;
  logic        image_end;
  logic [2:0]  error_code;
  modport source (output valid, result_kind, image_width, image_height, max_value,
                  wide_samples, sample, channel, column, row, image_end, error_code,
                  input ready);
  modport sink (input valid, result_kind, image_width, image_height, max_value,
                wide_samples, sample, channel, column, row, image_end, error_code,
                output ready);
endinterface

[rtl/ppmd_ctrl.sv]
// controller: input handshake and divider sequencing
module ppmd_ctrl import ppmd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic {S_ACCEPT, S_DIVIDE} state_t;
  state_t state;

  always_comb begin
    in_ready     = (state == S_ACCEPT) && sts.out_free;
    cmd.take     = in_valid && in_ready;
    cmd.div_step = (state == S_DIVIDE) && !sts.div_done;
    cmd.div_load = (state == S_DIVIDE) && sts.div_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCEPT;
    end else begin
      unique case (state)
        S_ACCEPT: if (cmd.take && sts.need_div) state <= S_DIVIDE;
        S_DIVIDE: if (sts.div_done) state <= S_ACCEPT;
        default:  state <= S_ACCEPT;
      endcase
    end
  end

endmodule

[rtl/ppmd_datapath.sv]
// datapath: header parser, sample counters, serial divider, result register
module ppmd_datapath import ppmd_pkg::*; #(
  parameter int DIM_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  ppmd_in_if.sink in_ch,
  ppmd_out_if.source out_ch,
  input  dp_cmd_t cmd,
  output dp_sts_t sts
);

  localparam int ACCW = (DIM_BITS > 17) ? DIM_BITS : 17;
  localparam logic [ACCW-1:0] ACC_CAP = {ACCW{1'b1}};
  localparam logic [ACCW-1:0] DIM_MAX = ACCW'({DIM_BITS{1'b1}});

  typedef enum logic [3:0] {
    PH_P, PH_DIGIT, PH_W_SKIP, PH_W_NUM, PH_H_SKIP, PH_H_NUM, PH_M_SKIP, PH_M_NUM,
    PH_S_SKIP, PH_S_NUM, PH_BIN, PH_IDLE
  } phase_t;

  typedef struct packed {
    phase_t              ph;
    logic                bin;
    logic                cmt;
    logic [ACCW-1:0]     acc;
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
    logic [16:0]         m;
    logic [1:0]          chn;
    logic [DIM_BITS-1:0] col;
    logic [DIM_BITS-1:0] row;
    logic [8:0]          hold;
  } parse_t;

  localparam parse_t PARSE_RESET = '{ph: PH_P, default: '0};

  parse_t ps, cur, nxt;

  logic [7:0]      b;
  logic            ws, dig, last, put, p3, chk, hdr, hdr_end, div;
  logic [2:0]      term, fcode;
  logic [ACCW+3:0] acc10;
  logic [ACCW-1:0] mclamp;
  logic [15:0]     pval, v16;
  logic [31:0]     num;
  logic            r_valid;
  logic [1:0]      r_kind;

  logic [16:0] rem, rem_next;
  logic [15:0] quo, quo_next;
  logic [17:0] trial;
  logic        trial_ge;
  logic        dsat, dwide, ddone;
  logic [3:0]  dcnt;

  always_comb begin
    b     = in_ch.in_byte;
    cur   = in_ch.start_of_file ? PARSE_RESET : ps;
    nxt   = cur;
    ws    = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    dig   = (b >= CH_0) && (b <= CH_9);
    term  = (ws || b == CH_HASH) ? ERR_NONE : ((b == CH_NUL) ? ERR_TRUNCATED : ERR_HEADER);
    last  = (cur.chn == 2'd2) && ({1'b0, cur.col} + 1'b1 == {1'b0, cur.w}) &&
            ({1'b0, cur.row} + 1'b1 == {1'b0, cur.h});
    acc10 = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + (ACCW+4)'(b - CH_0);
    mclamp = (cur.acc > ACCW'(MAXVAL_CLAMP)) ? ACCW'(MAXVAL_CLAMP) : cur.acc;
    fcode = ERR_NONE;
    p3 = 1'b0; chk = 1'b0; put = 1'b0; hdr = 1'b0; hdr_end = 1'b0; div = 1'b0;
    pval = '0; v16 = '0; num = '0;
    if (cur.ph == PH_IDLE) begin
      nxt = cur;
    end else if (in_ch.stream_end) begin
      if (cur.ph == PH_S_NUM && last) p3 = 1'b1;
      else fcode = ERR_TRUNCATED;
    end else begin
      unique case (cur.ph)
        PH_P: begin
          if (b != CH_P) fcode = ERR_MAGIC;
          else nxt.ph = PH_DIGIT;
        end
        PH_DIGIT: begin
          if (b == CH_3) nxt.bin = 1'b0;
          else if (b == CH_6) nxt.bin = 1'b1;
          else fcode = ERR_MAGIC;
          nxt.cmt = 1'b0;
          nxt.ph = PH_W_SKIP;
        end
        PH_W_SKIP, PH_H_SKIP, PH_M_SKIP, PH_S_SKIP: begin
          priority if (b == CH_NUL) fcode = ERR_TRUNCATED;
          else if (cur.cmt) begin
            if (b == CH_LF) nxt.cmt = 1'b0;
          end else if (b == CH_HASH) nxt.cmt = 1'b1;
          else if (ws) nxt.cmt = 1'b0;
          else if (!dig) fcode = ERR_HEADER;
          else begin
            nxt.acc = ACCW'(b - CH_0);
            unique case (cur.ph)
              PH_W_SKIP: nxt.ph = PH_W_NUM;
              PH_H_SKIP: nxt.ph = PH_H_NUM;
              PH_M_SKIP: nxt.ph = PH_M_NUM;
              default:   nxt.ph = PH_S_NUM;
            endcase
          end
        end
        PH_W_NUM, PH_H_NUM, PH_M_NUM, PH_S_NUM: begin
          if (dig) begin
            nxt.acc = (acc10 > (ACCW+4)'(ACC_CAP)) ? ACC_CAP : acc10[ACCW-1:0];
          end else if (cur.ph == PH_S_NUM) begin
            p3 = 1'b1;
            chk = 1'b1;
          end else if (term != ERR_NONE) begin
            fcode = term;
          end else if (cur.ph != PH_M_NUM) begin
            if (cur.acc > DIM_MAX) fcode = ERR_HEADER;
            else begin
              if (cur.ph == PH_W_NUM) begin
                nxt.w = cur.acc[DIM_BITS-1:0];
                nxt.ph = PH_H_SKIP;
              end else begin
                nxt.h = cur.acc[DIM_BITS-1:0];
                nxt.ph = PH_M_SKIP;
              end
              nxt.cmt = (b == CH_HASH);
            end
          end else if (cur.bin && b == CH_HASH) begin
            fcode = ERR_HEADER;
          end else if (mclamp == '0) begin
            fcode = ERR_HEADER;
          end else begin
            nxt.m = mclamp[16:0];
            nxt.cmt = (b == CH_HASH);
            hdr = 1'b1;
            if (cur.w == '0 || cur.h == '0) begin
              hdr_end = 1'b1;
              nxt.ph = PH_IDLE;
            end else begin
              nxt.ph = cur.bin ? PH_BIN : PH_S_SKIP;
            end
          end
        end
        PH_BIN: begin
          if (cur.m > NARROW_MAX) begin
            if (!cur.hold[8]) begin
              nxt.hold = {1'b1, b};
            end else begin
              v16 = {cur.hold[7:0], b};
              nxt.hold = '0;
              num = {v16, 16'h0000} - {16'h0000, v16};
              div = 1'b1;
              put = 1'b1;
            end
          end else begin
            v16 = {8'h00, b};
            num = {16'h0000, b, 8'h00} - {24'h000000, b};
            div = 1'b1;
            put = 1'b1;
          end
        end
        default: nxt.ph = PH_IDLE;
      endcase
    end
    if (p3) begin
      if (!last && chk && term != ERR_NONE) fcode = term;
      else if (cur.acc > ACCW'(cur.m)) fcode = ERR_OVER_MAX;
      else begin
        put = 1'b1;
        pval = (cur.acc > ACCW'(17'hffff)) ? 16'hffff : cur.acc[15:0];
        if (!last) begin
          nxt.cmt = (b == CH_HASH);
          nxt.ph = PH_S_SKIP;
        end
      end
    end
    if (put) begin
      if (last) nxt.ph = PH_IDLE;
      else if (cur.chn == 2'd2) begin
        nxt.chn = '0;
        if ({1'b0, cur.col} + 1'b1 >= {1'b0, cur.w}) begin
          nxt.col = '0;
          nxt.row = cur.row + 1'b1;
        end else begin
          nxt.col = cur.col + 1'b1;
        end
      end else begin
        nxt.chn = cur.chn + 1'b1;
      end
    end
    if (fcode != ERR_NONE) begin
      nxt.ph = PH_IDLE;
      div = 1'b0;
      put = 1'b0;
    end
    r_valid = put || hdr || (fcode != ERR_NONE);
    priority if (fcode != ERR_NONE) r_kind = KIND_ERROR;
    else if (put) r_kind = KIND_SAMPLE;
    else r_kind = KIND_HEADER;
  end

  always_comb begin
    trial    = {rem, quo[QUO_BITS-1]};
    trial_ge = trial >= {1'b0, ps.m};
    rem_next = trial_ge ? 17'(trial - {1'b0, ps.m}) : trial[16:0];
    quo_next = {quo[QUO_BITS-2:0], trial_ge};
  end

  assign sts.out_free = !out_ch.valid || out_ch.ready;
  assign sts.need_div = div;
  assign sts.div_done = ddone;

  always_ff @(posedge clk) begin
    if (rst) begin
      ps <= PARSE_RESET;
      out_ch.valid <= 1'b0;
      ddone <= 1'b0;
      dcnt <= '0;
    end else begin
      if (cmd.div_load || (cmd.take && r_valid && !div)) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      if (cmd.take) begin
        ps <= nxt;
        if (div) begin
          rem   <= {1'b0, num[31:16]};
          quo   <= num[15:0];
          dsat  <= {1'b0, v16} > cur.m;
          dwide <= cur.m > NARROW_MAX;
          dcnt  <= '0;
          ddone <= 1'b0;
        end
      end
      if (cmd.div_step) begin
        rem  <= rem_next;
        quo  <= quo_next;
        dcnt <= dcnt + 1'b1;
        if (dcnt == 4'(QUO_BITS - 1)) ddone <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && r_valid) begin
      out_ch.result_kind  <= r_kind;
      out_ch.image_width  <= 16'(nxt.w);
      out_ch.image_height <= 16'(nxt.h);
      out_ch.max_value    <= nxt.m;
      out_ch.wide_samples <= nxt.m > NARROW_MAX;
      out_ch.channel      <= (r_kind == KIND_SAMPLE) ? cur.chn : 2'd0;
      out_ch.column       <= (r_kind == KIND_SAMPLE) ? 16'(cur.col) : 16'd0;
      out_ch.row          <= (r_kind == KIND_SAMPLE) ? 16'(cur.row) : 16'd0;
      out_ch.image_end    <= (r_kind == KIND_SAMPLE) ? last : hdr_end;
      out_ch.error_code   <= fcode;
      if (!div) out_ch.sample <= pval;
    end
    if (cmd.div_load) begin
      out_ch.sample <= dsat ? (dwide ? 16'hffff : 16'h00ff) : quo;
    end
  end

endmodule

[rtl/ppm_stream_decoder_top.sv]
// top level of the ppm stream decoder
// Takes a P3 or P6 file one byte per transaction and returns a header result, one
// result per channel sample, or an error result. Header bytes, P3 bytes and the
// first byte of a 16-bit P6 sample need no divide. A P6 sample byte that completes
// a value is scaled on a radix-2 divider that retires one quotient bit per cycle
// over 16 bits, and the result register is then loaded from the quotient.
// A finished result in the output register holds off the next byte until that
// result transaction is taken; both can happen at the same clock edge.
module ppm_stream_decoder_top import ppmd_pkg::*; #(
  parameter int DIM_BITS = 16
) (
  input logic clk,
  input logic rst,
  ppmd_in_if.sink in_ch,
  ppmd_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ppmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppmd_datapath #(.DIM_BITS(DIM_BITS)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

  a_no_out_while_dividing: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !out_ch.valid) else $error("result valid during divide");

  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !in_ch.ready) else $error("input ready during divide");

  a_load_after_step: assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |=> out_ch.valid) else $error("divide result not presented");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.result_kind == KIND_ERROR) |->
      (out_ch.sample == 16'd0 && out_ch.error_code != ERR_NONE))
    else $error("malformed error transaction");

endmodule

[verif/ppm_stream_decoder_top_test.sv]
// self-checking testbench of the ppm stream decoder top level
module ppm_stream_decoder_top_test;
  import ppmd_pkg::*;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_FORMAT, PH_W_SKIP, PH_W_NUM, PH_H_SKIP, PH_H_NUM,
    PH_M_SKIP, PH_M_NUM, PH_S_SKIP, PH_S_NUM, PH_BIN, PH_IDLE
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_file;
    logic       stream_end;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [16:0] max_value;
    logic        wide_samples;
    logic [15:0] sample;
    logic [1:0]  channel;
    logic [15:0] column;
    logic [15:0] row;
    logic        image_end;
    logic [2:0]  error_code;
  } decode_result_t;

  typedef struct packed {
    byte_item_t     item;
    logic           known;
    decode_result_t res;
  } table_row_t;

  localparam logic [19:0] ACC_CAP = 20'h1ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  ppmd_in_if in_ch();
  ppmd_out_if out_ch();

  ppm_stream_decoder_top dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  phase_t      phase;
  logic        bin_fmt;
  logic        in_cmt;
  logic [19:0] acc;
  logic [15:0] w_reg, h_reg;
  logic [16:0] mx_reg;
  logic [1:0]  ch_cnt;
  logic [15:0] col_cnt, row_cnt;
  logic [8:0]  hi_hold;

  decode_result_t expected_results[$];
  decode_result_t typed_results[$];
  logic           typed_known[$];
  byte_item_t     pending_bytes[$];
  logic           pending_known[$];
  decode_result_t pending_typed[$];
  int errors = 0;
  bit no_idle = 0;
  int rx_idle = 0;

  task automatic report(input string what, input decode_result_t got, input decode_result_t exp);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, exp);
  endtask

  function automatic void decoder_reset();
    phase = PH_MAGIC; bin_fmt = 0; in_cmt = 0; acc = 0; w_reg = 0; h_reg = 0;
    mx_reg = 0; ch_cnt = 0; col_cnt = 0; row_cnt = 0; hi_hold = 0;
  endfunction

  function automatic decode_result_t make_res(logic [1:0] kind, logic [15:0] smp,
                                              logic last, logic [2:0] err);
    decode_result_t r;
    logic s;
    s = (kind == KIND_SAMPLE);
    r.result_kind = kind; r.image_width = w_reg; r.image_height = h_reg;
    r.max_value = mx_reg; r.wide_samples = mx_reg > 17'd255; r.sample = smp;
    r.channel = s ? ch_cnt : 2'd0; r.column = s ? col_cnt : 16'd0;
    r.row = s ? row_cnt : 16'd0; r.image_end = last; r.error_code = err;
    return r;
  endfunction

  function automatic bit is_space(logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic logic [2:0] end_code(logic [7:0] b);
    if (is_space(b) || b == CH_HASH) return ERR_NONE;
    return (b == CH_NUL) ? ERR_TRUNCATED : ERR_HEADER;
  endfunction

  function automatic bit at_last();
    return ch_cnt == 2 && {1'b0, col_cnt} + 17'd1 == {1'b0, w_reg} &&
           {1'b0, row_cnt} + 17'd1 == {1'b0, h_reg};
  endfunction

  function automatic bit error_out(logic [2:0] code, output decode_result_t r);
    phase = PH_IDLE;
    r = make_res(KIND_ERROR, 0, 0, code);
    return 1;
  endfunction

  function automatic bit sample_out(logic [15:0] v, output decode_result_t r);
    bit last;
    last = at_last();
    r = make_res(KIND_SAMPLE, v, last, ERR_NONE);
    if (last) begin
      phase = PH_IDLE;
      return 1;
    end
    ch_cnt++;
    if (ch_cnt == 3) begin
      ch_cnt = 0;
      col_cnt++;
      if (col_cnt >= w_reg) begin
        col_cnt = 0;
        row_cnt++;
      end
    end
    return 1;
  endfunction

  function automatic bit ascii_sample_done(logic [7:0] b, bit checked, output decode_result_t r);
    bit last;
    logic [19:0] v;
    logic [2:0] t;
    last = at_last();
    v = acc;
    t = end_code(b);
    if (!last && checked && t != ERR_NONE) return error_out(t, r);
    if (v > {3'd0, mx_reg}) return error_out(ERR_OVER_MAX, r);
    void'(sample_out(v > 20'd65535 ? 16'hffff : v[15:0], r));
    if (!last) begin
      in_cmt = (b == CH_HASH);
      phase = PH_S_SKIP;
    end
    return 1;
  endfunction

  function automatic bit header_num_done(logic [7:0] b, output decode_result_t r);
    logic [2:0] t;
    logic [19:0] v;
    t = end_code(b);
    v = acc;
    if (t != ERR_NONE) return error_out(t, r);
    if (phase == PH_W_NUM || phase == PH_H_NUM) begin
      if (v > 20'hffff) return error_out(ERR_HEADER, r);
      if (phase == PH_W_NUM) w_reg = v[15:0];
      else h_reg = v[15:0];
      in_cmt = (b == CH_HASH);
      phase = phase_t'(phase + 1);
      return 0;
    end
    if (bin_fmt && b == CH_HASH) return error_out(ERR_HEADER, r);
    if (v > {3'd0, MAXVAL_CLAMP}) v = {3'd0, MAXVAL_CLAMP};
    if (v == 0) return error_out(ERR_HEADER, r);
    mx_reg = v[16:0];
    in_cmt = (b == CH_HASH);
    if (w_reg == 0 || h_reg == 0) begin
      phase = PH_IDLE;
      r = make_res(KIND_HEADER, 0, 1, ERR_NONE);
      return 1;
    end
    phase = bin_fmt ? PH_BIN : PH_S_SKIP;
    r = make_res(KIND_HEADER, 0, 0, ERR_NONE);
    return 1;
  endfunction

  function automatic bit binary_byte(logic [7:0] b, output decode_result_t r);
    logic [47:0] s;
    logic [15:0] v;
    if (mx_reg > 17'd255) begin
      if (!hi_hold[8]) begin
        hi_hold = {1'b1, b};
        return 0;
      end
      v = {hi_hold[7:0], b};
      hi_hold = 0;
      s = (48'(v) * 48'd65535) / 48'(mx_reg);
      if (s > 48'd65535) s = 48'd65535;
    end else begin
      s = (48'(b) * 48'd255) / 48'(mx_reg);
      if (s > 48'd255) s = 48'd255;
    end
    return sample_out(s[15:0], r);
  endfunction

  function automatic bit decode_byte(byte_item_t it, output decode_result_t r);
    logic [7:0] b;
    logic [31:0] v;
    b = it.in_byte;
    r = '0;
    if (it.start_of_file) decoder_reset();
    if (phase == PH_IDLE) return 0;
    if (it.stream_end) begin
      if (phase == PH_S_NUM && at_last()) return ascii_sample_done(CH_NUL, 0, r);
      return error_out(ERR_TRUNCATED, r);
    end
    case (phase)
      PH_MAGIC: begin
        if (b != CH_P) return error_out(ERR_MAGIC, r);
        phase = PH_FORMAT;
        return 0;
      end
      PH_FORMAT: begin
        if (b == CH_3) bin_fmt = 0;
        else if (b == CH_6) bin_fmt = 1;
        else return error_out(ERR_MAGIC, r);
        in_cmt = 0;
        phase = PH_W_SKIP;
        return 0;
      end
      PH_W_SKIP, PH_H_SKIP, PH_M_SKIP, PH_S_SKIP: begin
        if (b == CH_NUL) return error_out(ERR_TRUNCATED, r);
        if (in_cmt) begin
          if (b == CH_LF) in_cmt = 0;
          return 0;
        end
        if (b == CH_HASH) begin
          in_cmt = 1;
          return 0;
        end
        if (is_space(b)) return 0;
        if (!is_num(b)) return error_out(ERR_HEADER, r);
        acc = b - CH_0;
        phase = phase_t'(phase + 1);
        return 0;
      end
      PH_W_NUM, PH_H_NUM, PH_M_NUM, PH_S_NUM: begin
        if (is_num(b)) begin
          v = 32'(acc) * 32'd10 + 32'(b - CH_0);
          acc = (v > 32'(ACC_CAP)) ? ACC_CAP : v[19:0];
          return 0;
        end
        if (phase == PH_S_NUM) return ascii_sample_done(b, 1, r);
        return header_num_done(b, r);
      end
      PH_BIN: return binary_byte(b, r);
      default: begin
        phase = PH_IDLE;
        return 0;
      end
    endcase
  endfunction

  // stimulus building
  function automatic byte_item_t mk(logic [7:0] b, bit sof = 0, bit se = 0);
    byte_item_t it;
    it.in_byte = b; it.start_of_file = sof; it.stream_end = se;
    return it;
  endfunction

  task automatic push(byte_item_t it, bit known = 0, decode_result_t r = '0);
    pending_bytes.push_back(it);
    pending_known.push_back(known);
    pending_typed.push_back(r);
  endtask

  task automatic push_str(string s, bit sof = 0);
    for (int i = 0; i < s.len(); i++) push(mk(s[i], sof && i == 0));
  endtask

  function automatic string sep();
    case ($urandom_range(0, 9))
      0: return "\n";
      1: return "\t";
      2: return " # note\n ";
      3: return "\r\n";
      default: return " ";
    endcase
  endfunction

  task automatic push_number(int unsigned n);
    push_str($sformatf("%0d", n));
  endtask

  task automatic push_file();
    int unsigned w, h, m, total, v;
    bit p6, corrupt;
    w = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3);
    h = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
    case ($urandom_range(0, 5))
      0: m = $urandom_range(1, 255);
      1: m = 255;
      2: m = $urandom_range(256, 65535);
      3: m = 65535;
      4: m = $urandom_range(65536, 99999);
      default: m = $urandom_range(1, 15);
    endcase
    p6 = $urandom_range(0, 1);
    corrupt = $urandom_range(0, 7) == 0;
    push_str(p6 ? "P6" : "P3", 1);
    push_str(sep()); push_number(w); push_str(sep()); push_number(h);
    push_str(sep()); push_number(m);
    if (p6) push(mk($urandom_range(0, 1) ? CH_LF : CH_SPACE));
    else push_str(sep());
    if (m > 65536) m = 65536;
    total = w * h * 3;
    for (int i = 0; i < total; i++) begin
      if (corrupt && $urandom_range(0, 5) == 0) begin
        push(mk($urandom_range(0, 255), 0, $urandom_range(0, 3) == 0));
        break;
      end
      if (p6) begin
        push(mk($urandom_range(0, 255)));
        if (m > 255) push(mk($urandom_range(0, 255)));
      end else begin
        v = $urandom_range(0, 15) == 0 ? m + 1 : $urandom_range(0, m);
        push_number(v);
        if (i != total - 1) push_str(sep());
      end
    end
    if (!p6 && $urandom_range(0, 1)) push(mk(0, 0, 1));
  endtask

  // directed rows: expected result typed where it is obvious
  task automatic directed_table();
    table_row_t rows[$];
    decode_result_t e;
    e = '0; e.result_kind = KIND_ERROR; e.error_code = ERR_MAGIC;
    rows.push_back({mk(8'h51, 1), 1'b1, e});
    rows.push_back({mk(8'hff, 1), 1'b1, e});
    rows.push_back({mk(CH_P, 1), 1'b0, decode_result_t'(0)});
    rows.push_back({mk(8'h35), 1'b1, e});
    e.error_code = ERR_TRUNCATED;
    rows.push_back({mk(CH_P, 1, 1), 1'b1, e});
    foreach (rows[i]) push(rows[i].item, rows[i].known, rows[i].res);
    push_str("P3 2 1 7 0 7 8", 1);
    push_str("P6\n1 1 255\n", 1); push(mk(8'h00)); push(mk(8'hff)); push(mk(8'h80));
    push_str("P6 1 1 65535 ", 1);
    push(mk(8'hff)); push(mk(8'hff)); push(mk(8'h00)); push(mk(8'h00));
    push(mk(8'h12)); push(mk(8'h34));
    push_str("P6 1 1 300#", 1);
    push_str("P3 0 5 9 ", 1);
    push_str("P3 1 1 0 ", 1);
    push_str("P3 70000 ", 1);
    push_str("P3 1 1 999999999 65536 1 2", 1); push(mk(0, 0, 1));
    push_str("P3 #c", 1); push(mk(CH_NUL));
    push_str("P3 1x", 1);
    push_str("P3 1 1 5 3", 1); push(mk(CH_NUL));
  endtask

  // sender
  task automatic send_all();
    byte_item_t it;
    while (pending_bytes.size() > 0) begin
      it = pending_bytes.pop_front();
      void'(pending_known.pop_front());
      void'(pending_typed.pop_front());
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.in_byte <= it.in_byte;
      in_ch.start_of_file <= it.start_of_file;
      in_ch.stream_end <= it.stream_end;
      @(posedge clk iff in_ch.ready);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // predict on acceptance, checked against typed rows where given
  decode_result_t pred;
  byte_item_t acc_item;
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      acc_item.in_byte = in_ch.in_byte;
      acc_item.start_of_file = in_ch.start_of_file;
      acc_item.stream_end = in_ch.stream_end;
      if (decode_byte(acc_item, pred)) expected_results.push_back(pred);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (no_idle) begin
      out_ch.ready <= 1'b1;
    end else if (rx_idle > 0) begin
      rx_idle <= rx_idle - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      rx_idle <= $urandom_range(1, 12) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  decode_result_t got;
  decode_result_t exp_res;
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.result_kind, out_ch.image_width, out_ch.image_height, out_ch.max_value,
             out_ch.wide_samples, out_ch.sample, out_ch.channel, out_ch.column, out_ch.row,
             out_ch.image_end, out_ch.error_code};
      if (expected_results.size() == 0) begin
        report("unexpected result", got, '0);
      end else begin
        exp_res = expected_results.pop_front();
        if (got !== exp_res) report("result fields", got, exp_res);
        if (typed_known.size() > 0) begin
          if (typed_known.pop_front() && got !== typed_results[0])
            report("typed row", got, typed_results[0]);
          void'(typed_results.pop_front());
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int guard;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.start_of_file = 1'b0;
    in_ch.stream_end = 1'b0;
    decoder_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    directed_table();
    // typed rows come first and each known row yields a result, so queue order lines up
    foreach (pending_known[i]) begin
      if (pending_known[i]) begin
        typed_known.push_back(1'b1);
        typed_results.push_back(pending_typed[i]);
      end
    end
    send_all();
    while (expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    while (pending_bytes.size() < 500) push_file();
    send_all();
    // wait for the output side to drain
    while (expected_results.size() > 0) @(posedge clk);
    while (pending_bytes.size() < 250) push_file();
    no_idle = 1;
    send_all();
    guard = 0;
    while (expected_results.size() > 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
